@@ rtl/mcr_pkg.sv @@
package mcr_pkg;

	// coordinate and accumulator widths
	localparam int COORD_BITS = 12;
	localparam int RAD_BITS   = COORD_BITS - 1;
	localparam int PIX_BITS   = COORD_BITS + 1;
	localparam int DEC_BITS   = COORD_BITS + 2;

	// points per symmetric set
	localparam int SET_POINTS = 8;
	localparam int IDX_BITS   = $clog2(SET_POINTS);
	localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(SET_POINTS - 1);

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [PIX_BITS-1:0]   pix_t;
	typedef logic signed [DEC_BITS-1:0]   dec_t;
	typedef logic [RAD_BITS-1:0]          rad_t;
	typedef logic [IDX_BITS-1:0]          idx_t;

	typedef enum logic [0:0] {
		OP_START = 1'b0,
		OP_STEP  = 1'b1
	} op_t;

endpackage

@@ rtl/mcr_if.sv @@
interface mcr_cmd_if;
	import mcr_pkg::*;

	logic   valid;
	logic   ready;
	op_t    operation;
	coord_t center_x;
	coord_t center_y;
	rad_t   radius;

	modport source (output valid, operation, center_x, center_y, radius, input ready);
	modport sink   (input valid, operation, center_x, center_y, radius, output ready);
endinterface

interface mcr_pix_if;
	import mcr_pkg::*;

	logic valid;
	logic ready;
	pix_t pixel_x;
	pix_t pixel_y;
	logic last;
	logic done_res;

	modport source (output valid, pixel_x, pixel_y, last, done_res, input ready);
	modport sink   (input valid, pixel_x, pixel_y, last, done_res, output ready);
endinterface

@@ rtl/midpoint_circle_rasterizer.sv @@
// items go to the circle state and sequencer, then points to the output register
// an item that emits gives eight points, one per cycle while the result side is ready
// a step while idle emits nothing
// the next item is accepted in the cycle the eighth point moves to the output register
// arst_n clears position, decision, center and active; the block comes up idle
module midpoint_circle_rasterizer (
	input  logic       clk,
	input  logic       arst_n,
	mcr_cmd_if.sink    cmd,
	mcr_pix_if.source  pix
);
	import mcr_pkg::*;

	coord_t cur_x_q, cur_y_q, held_cx_q, held_cy_q;
	dec_t   decision_q;
	logic   active_q;
	logic   busy_q;
	idx_t   idx_q;
	logic   out_valid_q;
	pix_t   out_x_q, out_y_q;
	logic   out_last_q, out_done_q;

	logic   out_load, set_end, accept, emit;
	coord_t step_x, step_y, start_y;
	dec_t   step_dec, start_dec, nx_w, ny_w;
	pix_t   pt_x, pt_y;

	// handshake control
	assign out_load = !out_valid_q || pix.ready;
	assign set_end  = busy_q && (idx_q == LAST_IDX) && out_load;
	assign cmd.ready = !busy_q || set_end;
	assign accept   = cmd.valid && cmd.ready;
	assign emit     = accept && ((cmd.operation == OP_START) || active_q);

	// midpoint step
	assign step_x = cur_x_q + COORD_BITS'(1);
	assign step_y = decision_q[DEC_BITS-1] ? cur_y_q : cur_y_q - COORD_BITS'(1);
	assign nx_w   = DEC_BITS'(step_x);
	assign ny_w   = DEC_BITS'(step_y);
	always_comb begin
		if (decision_q[DEC_BITS-1]) begin
			step_dec = decision_q + (nx_w <<< 1) + DEC_BITS'(1);
		end else begin
			step_dec = decision_q + (nx_w <<< 1) + DEC_BITS'(1) - (ny_w <<< 1);
		end
	end

	// start values
	assign start_y   = COORD_BITS'(cmd.radius);
	assign start_dec = DEC_BITS'(1) - DEC_BITS'(cmd.radius);

	// circle state, updated when a start, or a step on an active circle, is accepted
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q    <= '0;
			cur_y_q    <= '0;
			decision_q <= '0;
			held_cx_q  <= '0;
			held_cy_q  <= '0;
			active_q   <= 1'b0;
		end else if (accept) begin
			if (cmd.operation == OP_START) begin
				held_cx_q  <= cmd.center_x;
				held_cy_q  <= cmd.center_y;
				cur_x_q    <= '0;
				cur_y_q    <= start_y;
				decision_q <= start_dec;
				active_q   <= (start_y >= 0);
			end else if (active_q) begin
				cur_x_q    <= step_x;
				cur_y_q    <= step_y;
				decision_q <= step_dec;
				active_q   <= (step_x <= step_y);
			end
		end
	end

	// point sequencer over the eight octants
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else begin
			priority if (emit) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (busy_q && out_load) begin
				busy_q <= (idx_q != LAST_IDX);
				idx_q  <= idx_q + IDX_BITS'(1);
			end
		end
	end

	mcr_octant u_octant (
		.idx (idx_q),
		.cx  (held_cx_q),
		.cy  (held_cy_q),
		.x   (cur_x_q),
		.y   (cur_y_q),
		.px  (pt_x),
		.py  (pt_y)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load && busy_q) begin
			out_x_q    <= pt_x;
			out_y_q    <= pt_y;
			out_last_q <= (idx_q == LAST_IDX);
			out_done_q <= !active_q;
		end
	end

	assign pix.valid    = out_valid_q;
	assign pix.pixel_x  = out_x_q;
	assign pix.pixel_y  = out_y_q;
	assign pix.last     = out_last_q;
	assign pix.done_res = out_done_q;

	// checks
	a_idx_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(idx_q != '0) |-> busy_q)
		else $error("point index moved while no set is pending");

	a_hold_in: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !set_end) |-> !cmd.ready)
		else $error("item taken while a set is still being emitted");

	a_start_set: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd.operation == OP_START) |=> (busy_q && idx_q == '0 && active_q))
		else $error("start did not open a new set");

	a_idle_step: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd.operation == OP_STEP && !active_q) |=> !busy_q)
		else $error("idle step produced points");

	a_x_pos: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> !cur_x_q[COORD_BITS-1])
		else $error("x went negative on an active circle");
endmodule

@@ rtl/mcr_octant.sv @@
module mcr_octant (
	input  mcr_pkg::idx_t   idx,
	input  mcr_pkg::coord_t cx,
	input  mcr_pkg::coord_t cy,
	input  mcr_pkg::coord_t x,
	input  mcr_pkg::coord_t y,
	output mcr_pkg::pix_t   px,
	output mcr_pkg::pix_t   py
);
	import mcr_pkg::*;

	pix_t cx_w, cy_w, x_w, y_w;

	// sign extend to the pixel width, sums wrap there
	assign cx_w = PIX_BITS'(cx);
	assign cy_w = PIX_BITS'(cy);
	assign x_w  = PIX_BITS'(x);
	assign y_w  = PIX_BITS'(y);

	// pick the octant point for this slot of the set
	always_comb begin
		unique case (idx)
			3'd0: begin px = cx_w + x_w; py = cy_w + y_w; end
			3'd1: begin px = cx_w + y_w; py = cy_w + x_w; end
			3'd2: begin px = cx_w - y_w; py = cy_w + x_w; end
			3'd3: begin px = cx_w - x_w; py = cy_w + y_w; end
			3'd4: begin px = cx_w - x_w; py = cy_w - y_w; end
			3'd5: begin px = cx_w - y_w; py = cy_w - x_w; end
			3'd6: begin px = cx_w + y_w; py = cy_w - x_w; end
			default: begin px = cx_w + x_w; py = cy_w - y_w; end
		endcase
	end
endmodule
